// ----- hdl/mswin_pkg.sv -----
// ----------------------------------------------------------------------------
// mswin_pkg
// Shared constants, widths and beat types of the max-sum window search core.
// ----------------------------------------------------------------------------
package mswin_pkg;

  // Matrix geometry and sample format.
  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int MAX_WINDOW = 16;
  localparam int VALUE_BITS = 16;

  // Derived widths. The line store address is {row slot, column}, so
  // MAX_WINDOW and MAX_COLS are kept at powers of two.
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int LINE_DEPTH = MAX_WINDOW * MAX_COLS;
  localparam int LINE_AW    = SLOT_W + COL_W;
  localparam int COLSUM_W   = VALUE_BITS + SLOT_W;
  localparam int SUM_W      = 24;
  localparam int RS_W       = SUM_W + 1;

  // Configuration port.
  localparam int ROWS_CFG_W  = 8;
  localparam int COLS_CFG_W  = 8;
  localparam int WIN_CFG_W   = 5;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 8'd128;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd128;
  localparam logic [WIN_CFG_W-1:0]  WIN_RESET  = 5'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATRIX_ROWS = 2'd0,
    REG_MATRIX_COLS = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Result queue.
  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // Column sum stage output, one per accepted sample.
  typedef struct packed {
    logic                       valid;
    logic signed [COLSUM_W-1:0] colsum;
    logic                       first_col;
    logic                       c_ge_k;
    logic                       win;
    logic [ROW_W-1:0]           top;
    logic [COL_W-1:0]           left;
    logic                       last;
  } col_beat_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] best_sum;
    logic [ROW_W-1:0]        top_row;
    logic [COL_W-1:0]        left_col;
    logic                    found;
  } result_t;

  // Frame-final beats still inside the window stages.
  typedef struct packed {
    logic s2_final;
    logic s3_final;
  } win_status_t;

endpackage

// ----- hdl/mswin_sample_if.sv -----
// ----------------------------------------------------------------------------
// mswin_sample_if
// Input channel: one signed matrix element per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mswin_sample_if import mswin_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

// ----- hdl/mswin_result_if.sv -----
// ----------------------------------------------------------------------------
// mswin_result_if
// Result channel: best window sum and its corner, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mswin_result_if import mswin_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] best_sum;
  logic [ROW_W-1:0]        top_row;
  logic [COL_W-1:0]        left_col;
  logic                    found;

  modport source (output valid, output best_sum, output top_row, output left_col,
                  output found, input ready);
  modport sink (input valid, input best_sum, input top_row, input left_col,
                input found, output ready);
endinterface

// ----- hdl/max_sum_window_search_core.sv -----
// ----------------------------------------------------------------------------
// max_sum_window_search_core
// Finds the largest k by k window sum of a raster-streamed matrix and its
// top-left corner; one result per matrix after its last element.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle. The input stalls only when eight results
//   are queued or in flight and the result channel is not taking them.
// Result path: after the last sample of a matrix is accepted, its result passes
//   the column sum stage, running sum stage, compare stage and queue.
// Reset: synchronous; registers return to 128 rows, 128 columns, k = 3. The
//   line store is not cleared and needs no clearing pass after reset.
module max_sum_window_search_core import mswin_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  mswin_sample_if.sink           samples,
  mswin_result_if.source         results
);

  logic [ROWS_CFG_W-1:0] rows_cfg;
  logic [COLS_CFG_W-1:0] cols_cfg;
  logic [WIN_CFG_W-1:0]  win_cfg;

  logic                  cfg_clear;
  logic [ROW_W-1:0]      last_row;
  logic [COL_W-1:0]      last_col;
  logic                  k_ok;
  logic [SLOT_W-1:0]     kidx;
  logic                  accept;

  col_beat_t             beat;
  win_status_t           status;
  logic                  push;
  result_t               push_data;
  logic [OUTQ_CNT_W-1:0] q_count;
  logic [OUTQ_CNT_W:0]   pending;

  // Any write to a known register restarts the frame.
  assign cfg_clear = cfg_write && ((cfg_index == REG_MATRIX_ROWS) ||
                                   (cfg_index == REG_MATRIX_COLS) ||
                                   (cfg_index == REG_WINDOW_SIZE));

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
      win_cfg  <= WIN_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_MATRIX_ROWS: rows_cfg <= cfg_data[ROWS_CFG_W-1:0];
        REG_MATRIX_COLS: cols_cfg <= cfg_data[COLS_CFG_W-1:0];
        REG_WINDOW_SIZE: win_cfg  <= cfg_data[WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // A dimension of zero counts as one, anything above the maximum as the
  // maximum.
  always_comb begin
    if (rows_cfg == '0) begin
      last_row = '0;
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      last_row = ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = ROW_W'(rows_cfg - ROWS_CFG_W'(1));
    end
    if (cols_cfg == '0) begin
      last_col = '0;
    end else if (int'(cols_cfg) > MAX_COLS) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(cols_cfg - COLS_CFG_W'(1));
    end
  end

  assign k_ok = (win_cfg != '0) && (int'(win_cfg) <= MAX_WINDOW);
  assign kidx = SLOT_W'(win_cfg - WIN_CFG_W'(1));

  // Every frame-final beat in flight is given a queue slot before it is
  // accepted; the pipeline itself never stalls.
  assign pending = (OUTQ_CNT_W+1)'(q_count)
                 + (OUTQ_CNT_W+1)'(beat.valid && beat.last)
                 + (OUTQ_CNT_W+1)'(status.s2_final)
                 + (OUTQ_CNT_W+1)'(status.s3_final);
  assign samples.ready = (pending < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
  assign accept        = samples.valid && samples.ready;

  mswin_front u_front (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_clear),
    .accept   (accept),
    .sample   (samples.sample_value),
    .last_row (last_row),
    .last_col (last_col),
    .win_size (win_cfg),
    .k_ok     (k_ok),
    .kidx     (kidx),
    .beat     (beat)
  );

  mswin_window u_window (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_clear),
    .kidx      (kidx),
    .beat      (beat),
    .push      (push),
    .push_data (push_data),
    .status    (status)
  );

  mswin_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .results   (results),
    .count     (q_count)
  );

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (OUTQ_CNT_W+1)'(OUTQ_DEPTH))
    else $error("more results owed than the queue can hold");

endmodule

// ----- hdl/mswin_front.sv -----
// ----------------------------------------------------------------------------
// mswin_front
// Raster counters, line store and column sum memory. Produces the updated
// k-row column sum for every accepted sample.
// ----------------------------------------------------------------------------
module mswin_front import mswin_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         accept,
  input  logic signed [VALUE_BITS-1:0] sample,
  input  logic [ROW_W-1:0]             last_row,
  input  logic [COL_W-1:0]             last_col,
  input  logic [WIN_CFG_W-1:0]         win_size,
  input  logic                         k_ok,
  input  logic [SLOT_W-1:0]            kidx,
  output col_beat_t                    beat
);

  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  logic                         s1_valid;
  logic signed [VALUE_BITS-1:0] s1_v;
  logic [ROW_W-1:0]             s1_r;
  logic [COL_W-1:0]             s1_c;
  logic                         s1_last;
  logic                         s1_use_old;
  logic                         s1_c_ge_k;
  logic                         s1_win;

  logic signed [VALUE_BITS-1:0] line_mem [LINE_DEPTH];
  logic signed [COLSUM_W-1:0]   col_mem [MAX_COLS];

  logic signed [VALUE_BITS-1:0] line_rd;
  logic signed [COLSUM_W-1:0]   col_rd;
  logic                         fwd_line_hit;
  logic signed [VALUE_BITS-1:0] fwd_line_val;
  logic                         fwd_col_hit;
  logic signed [COLSUM_W-1:0]   fwd_col_val;

  logic [LINE_AW-1:0]           rd_addr;
  logic [LINE_AW-1:0]           wr_addr;
  logic                         at_last;
  logic                         row_ge_k;
  logic                         col_ge_k;
  logic                         in_win;
  logic signed [VALUE_BITS-1:0] line_old;
  logic signed [VALUE_BITS-1:0] old_term;
  logic signed [COLSUM_W-1:0]   col_old;
  logic signed [COLSUM_W-1:0]   colsum_new;

  // The value k rows up lives in slot (row - k) mod MAX_WINDOW.
  assign rd_addr = {row[SLOT_W-1:0] - win_size[SLOT_W-1:0], col};
  assign wr_addr = {s1_r[SLOT_W-1:0], s1_c};

  assign at_last  = (row == last_row) && (col == last_col);
  assign row_ge_k = k_ok && ({1'b0, row} >= (ROW_W+1)'(win_size));
  assign col_ge_k = k_ok && ({1'b0, col} >= (COL_W+1)'(win_size));
  assign in_win   = k_ok && (row >= ROW_W'(kidx)) && (col >= COL_W'(kidx));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row      <= '0;
      col      <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (at_last) begin
          row <= '0;
          col <= '0;
        end else if (col == last_col) begin
          row <= row + ROW_W'(1);
          col <= '0;
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v       <= sample;
      s1_r       <= row;
      s1_c       <= col;
      s1_last    <= at_last;
      s1_use_old <= row_ge_k;
      s1_c_ge_k  <= col_ge_k;
      s1_win     <= in_win;
    end
  end

  // Memories: registered reads issued with the sample, writes from stage 1.
  // A read that meets the stage 1 write of the same edge takes the
  // forwarded value instead of the stale memory word.
  always_ff @(posedge clk) begin
    line_rd      <= line_mem[rd_addr];
    col_rd       <= col_mem[col];
    fwd_line_hit <= s1_valid && (wr_addr == rd_addr);
    fwd_line_val <= s1_v;
    fwd_col_hit  <= s1_valid && (s1_c == col);
    fwd_col_val  <= colsum_new;
    if (s1_valid) begin
      line_mem[wr_addr] <= s1_v;
      col_mem[s1_c]     <= colsum_new;
    end
  end

  // Row 0 of a frame starts every column sum from zero, so the column
  // memory needs no clearing between frames.
  always_comb begin
    line_old   = fwd_line_hit ? fwd_line_val : line_rd;
    old_term   = s1_use_old ? line_old : '0;
    col_old    = (s1_r == '0) ? '0 : (fwd_col_hit ? fwd_col_val : col_rd);
    colsum_new = col_old + COLSUM_W'(s1_v) - COLSUM_W'(old_term);
  end

  always_comb begin
    beat.valid     = s1_valid;
    beat.colsum    = colsum_new;
    beat.first_col = (s1_c == '0);
    beat.c_ge_k    = s1_c_ge_k;
    beat.win       = s1_win;
    beat.top       = s1_r - ROW_W'(kidx);
    beat.left      = s1_c - COL_W'(kidx);
    beat.last      = s1_last;
  end

  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= last_col) && (row <= last_row))
    else $error("raster counter outside the matrix");

  a_fwd_after_beat: assert property (@(posedge clk) disable iff (rst)
    (fwd_col_hit || fwd_line_hit) |-> $past(s1_valid))
    else $error("forwarding hit without a stage 1 write");

endmodule

// ----- hdl/mswin_window.sv -----
// ----------------------------------------------------------------------------
// mswin_window
// Horizontal running sum over the last k column sums, then best-window
// tracking and result formation at the end of each frame.
// ----------------------------------------------------------------------------
module mswin_window import mswin_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [SLOT_W-1:0] kidx,
  input  col_beat_t         beat,
  output logic              push,
  output result_t           push_data,
  output win_status_t       status
);

  col_beat_t s2;

  logic signed [COLSUM_W-1:0] taps [MAX_WINDOW];
  logic signed [SUM_W-1:0]    rs;
  logic signed [RS_W-1:0]     rs_base;
  logic signed [RS_W-1:0]     rs_sub;
  logic signed [RS_W-1:0]     rs_next;

  logic             s3_valid;
  logic             s3_win;
  logic [ROW_W-1:0] s3_top;
  logic [COL_W-1:0] s3_left;
  logic             s3_last;

  logic signed [SUM_W-1:0] best;
  logic [ROW_W-1:0]        best_top;
  logic [COL_W-1:0]        best_left;
  logic                    any_win;

  logic                    take;
  logic signed [SUM_W-1:0] best_next;
  logic [ROW_W-1:0]        best_top_next;
  logic [COL_W-1:0]        best_left_next;
  logic                    any_win_next;

  // Stage 2: the tap k-1 back holds the column sum k columns to the left.
  // With k in range the window sum stays inside SUM_W bits; the extra bit
  // only covers the partial sum before the subtraction.
  always_comb begin
    rs_base = s2.first_col ? '0 : RS_W'(rs);
    rs_sub  = s2.c_ge_k ? RS_W'(taps[kidx]) : '0;
    rs_next = rs_base + RS_W'(s2.colsum) - rs_sub;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s2.valid <= 1'b0;
      s3_valid <= 1'b0;
      rs       <= '0;
    end else begin
      s2       <= beat;
      s3_valid <= s2.valid;
      if (s2.valid) begin
        rs <= rs_next[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      taps[0] <= s2.colsum;
      for (int i = 1; i < MAX_WINDOW; i++) begin
        taps[i] <= taps[i-1];
      end
      s3_win  <= s2.win;
      s3_top  <= s2.top;
      s3_left <= s2.left;
      s3_last <= s2.last;
    end
  end

  // Stage 3: only a strictly larger sum replaces the best, so the first
  // window in raster order wins a tie.
  always_comb begin
    take           = s3_valid && s3_win && (!any_win || (rs > best));
    best_next      = take ? rs : best;
    best_top_next  = take ? s3_top : best_top;
    best_left_next = take ? s3_left : best_left;
    any_win_next   = any_win || (s3_valid && s3_win);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      best      <= SUM_MIN;
      best_top  <= '0;
      best_left <= '0;
      any_win   <= 1'b0;
    end else if (s3_valid) begin
      if (s3_last) begin
        best      <= SUM_MIN;
        best_top  <= '0;
        best_left <= '0;
        any_win   <= 1'b0;
      end else begin
        best      <= best_next;
        best_top  <= best_top_next;
        best_left <= best_left_next;
        any_win   <= any_win_next;
      end
    end
  end

  always_comb begin
    push               = s3_valid && s3_last;
    push_data.found    = any_win_next;
    push_data.best_sum = any_win_next ? best_next : '0;
    push_data.top_row  = any_win_next ? best_top_next : '0;
    push_data.left_col = any_win_next ? best_left_next : '0;
    status.s2_final    = s2.valid && s2.last;
    status.s3_final    = s3_valid && s3_last;
  end

  a_window_found: assert property (@(posedge clk) disable iff (rst)
    (push && s3_win) |-> push_data.found)
    else $error("frame ends on a window but reports none found");

endmodule

// ----- hdl/mswin_outq.sv -----
// ----------------------------------------------------------------------------
// mswin_outq
// Small result queue that decouples the pipeline from the result channel.
// ----------------------------------------------------------------------------
module mswin_outq import mswin_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  mswin_result_if.source        results,
  output logic [OUTQ_CNT_W-1:0] count
);

  result_t              q [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wr_ptr;
  logic [OUTQ_AW-1:0]   rd_ptr;
  logic                 pop;

  assign pop              = results.valid && results.ready;
  assign results.valid    = (count != '0);
  assign results.best_sum = q[rd_ptr].best_sum;
  assign results.top_row  = q[rd_ptr].top_row;
  assign results.left_col = q[rd_ptr].left_col;
  assign results.found    = q[rd_ptr].found;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUTQ_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_AW'(1);
      end
      if (push && !pop) begin
        count <= count + OUTQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OUTQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> ((count < OUTQ_CNT_W'(OUTQ_DEPTH)) || pop))
    else $error("result queue overflow");

endmodule

// ----- tb/tb_max_sum_window_search_core.sv -----
// ----------------------------------------------------------------------------
// tb_max_sum_window_search_core
// Streams matrices into the max-sum window search core under a range of
// geometries and window sizes. Every result is checked against an in-bench
// prediction of the best window sum, its top-left corner and the found flag.
// Both channels idle at random, and geometry changes only happen while drained.
// ----------------------------------------------------------------------------
module tb_max_sum_window_search_core;
  import mswin_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam longint SUM_TOP = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint SUM_BOTTOM = -(longint'(1) <<< (SUM_W - 1));
  localparam int DRAIN_TAIL = 8;
  localparam int RANDOM_ITEMS = 100;

  typedef enum int {
    FILL_RANDOM, FILL_EXTREME, FILL_NARROW, FILL_NEGATIVE, FILL_FLAT, FILL_MAX, FILL_MIN
  } fill_t;

  class max_window_scoreboard;
    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [WIN_CFG_W-1:0]  win_reg;

    logic signed [VALUE_BITS-1:0] line_store [LINE_DEPTH];
    longint column_sums [MAX_COLS];
    longint running_sum;
    longint best_sum;
    int     best_top;
    int     best_left;
    bit     window_seen;
    int     cur_row;
    int     cur_col;

    result_t best_window_queue[$];
    int      mismatches;

    function new();
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      win_reg = WIN_RESET;
      mismatches = 0;
      foreach (line_store[i]) line_store[i] = '0;
      clear_frame();
    endfunction

    function void clear_frame();
      foreach (column_sums[i]) column_sums[i] = 0;
      running_sum = 0;
      best_sum = SUM_BOTTOM;
      best_top = 0;
      best_left = 0;
      window_seen = 1'b0;
      cur_row = 0;
      cur_col = 0;
    endfunction

    function int clamp_dim(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int frame_items();
      return clamp_dim(int'(rows_reg), MAX_ROWS) * clamp_dim(int'(cols_reg), MAX_COLS);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (cfg_reg_t'(index))
        REG_MATRIX_ROWS: rows_reg = data[ROWS_CFG_W-1:0];
        REG_MATRIX_COLS: cols_reg = data[COLS_CFG_W-1:0];
        REG_WINDOW_SIZE: win_reg = data[WIN_CFG_W-1:0];
        default: return;
      endcase
      clear_frame();
    endfunction

    // Advances the window search by one element and queues the matrix result
    // once its last element has been taken.
    function void absorb_sample(logic signed [VALUE_BITS-1:0] value);
      int nr;
      int nc;
      int k;
      int r;
      int c;
      bit k_ok;
      longint old;
      longint win_sum;
      result_t res;
      nr = clamp_dim(int'(rows_reg), MAX_ROWS);
      nc = clamp_dim(int'(cols_reg), MAX_COLS);
      k = int'(win_reg);
      k_ok = (k >= 1 && k <= MAX_WINDOW);
      r = cur_row;
      c = cur_col;
      old = 0;
      if (k_ok && r >= k) old = longint'(line_store[((r - k) % MAX_WINDOW) * MAX_COLS + c]);
      line_store[(r % MAX_WINDOW) * MAX_COLS + c] = value;
      column_sums[c] += longint'(value) - old;

      if (c == 0) running_sum = 0;
      running_sum += column_sums[c];
      if (k_ok && c >= k) running_sum -= column_sums[c - k];

      if (k_ok && r + 1 >= k && c + 1 >= k) begin
        win_sum = running_sum;
        if (win_sum > SUM_TOP) win_sum = SUM_TOP;
        if (win_sum < SUM_BOTTOM) win_sum = SUM_BOTTOM;
        // Only a strictly larger sum moves the corner, so ties keep the first.
        if (!window_seen || win_sum > best_sum) begin
          best_sum = win_sum;
          best_top = r + 1 - k;
          best_left = c + 1 - k;
        end
        window_seen = 1'b1;
      end

      if (r + 1 == nr && c + 1 == nc) begin
        res = '0;
        if (window_seen) begin
          res.best_sum = SUM_W'(best_sum);
          res.top_row = ROW_W'(best_top);
          res.left_col = COL_W'(best_left);
          res.found = 1'b1;
        end
        best_window_queue.push_back(res);
        clear_frame();
      end else if (c + 1 == nc) begin
        cur_col = 0;
        cur_row = r + 1;
      end else begin
        cur_col = c + 1;
      end
    endfunction

    function void check_best_window(result_t got);
      result_t exp;
      if (best_window_queue.size() == 0) begin
        $error("result beat with no result expected: best_sum %0d", got.best_sum);
        mismatches++;
        return;
      end
      exp = best_window_queue.pop_front();
      if (got.best_sum !== exp.best_sum) begin
        $error("best_sum: expected %0d, got %0d", exp.best_sum, got.best_sum);
        mismatches++;
      end
      if (got.top_row !== exp.top_row) begin
        $error("top_row: expected %0d, got %0d", exp.top_row, got.top_row);
        mismatches++;
      end
      if (got.left_col !== exp.left_col) begin
        $error("left_col: expected %0d, got %0d", exp.left_col, got.left_col);
        mismatches++;
      end
      if (got.found !== exp.found) begin
        $error("found: expected %0d, got %0d", exp.found, got.found);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return best_window_queue.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  mswin_sample_if sample_bus ();
  mswin_result_if result_bus ();

  max_sum_window_search_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (sample_bus),
    .results   (result_bus)
  );

  max_window_scoreboard board;
  bit sender_calm;
  bit receiver_calm;
  int stall_left;
  logic signed [VALUE_BITS-1:0] flat_value;
  int random_sent;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Result side backpressure: mostly short stalls, some long ones, and calm
  // stretches where ready simply stays high.
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) receiver_calm <= ~receiver_calm;
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
      if (!receiver_calm) begin
        case ($urandom_range(0, 9))
          0, 1: stall_left <= $urandom_range(1, 3);
          2: stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : 0;
          default: stall_left <= 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got.best_sum = result_bus.best_sum;
      got.top_row = result_bus.top_row;
      got.left_col = result_bus.left_col;
      got.found = result_bus.found;
      board.check_best_window(got);
    end
  end

  function automatic int pick_gap();
    int roll;
    if (sender_calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [VALUE_BITS-1:0] pick_sample(fill_t fill);
    case (fill)
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      FILL_NARROW: return VALUE_BITS'($urandom_range(0, 4)) - 16'sd2;
      FILL_NEGATIVE: return -VALUE_BITS'($urandom_range(1, 32768));
      FILL_FLAT: return flat_value;
      FILL_MAX: return 16'sh7FFF;
      FILL_MIN: return 16'sh8000;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Each task starts and ends on a falling edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    board.write_reg(index, data);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(input int rows, input int cols, input int win);
    logic [CFG_DATA_W-1:0] win_data;
    // Upper data bits above the window field are junk the block must drop.
    win_data = CFG_DATA_W'($urandom);
    win_data[WIN_CFG_W-1:0] = WIN_CFG_W'(win);
    write_reg(REG_MATRIX_ROWS, CFG_DATA_W'(rows));
    write_reg(REG_MATRIX_COLS, CFG_DATA_W'(cols));
    write_reg(REG_WINDOW_SIZE, win_data);
  endtask

  task automatic send_sample(input logic signed [VALUE_BITS-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.sample_value <= value;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    board.absorb_sample(value);
    @(negedge clk);
  endtask

  // Drops valid and waits for every outstanding result; with_tail adds the
  // pipeline latency so a register write cannot land on a frame in flight.
  task automatic settle(input bit with_tail);
    sample_bus.valid <= 1'b0;
    do @(negedge clk); while (board.outstanding() != 0);
    if (with_tail) repeat (DRAIN_TAIL) @(negedge clk);
  endtask

  task automatic send_matrices(input int count, input fill_t fill, input bit counted);
    int items;
    for (int m = 0; m < count; m++) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      flat_value = VALUE_BITS'($urandom);
      items = board.frame_items();
      for (int i = 0; i < items; i++) begin
        send_sample(pick_sample(fill));
        if (counted) random_sent++;
      end
      if ($urandom_range(0, 7) == 0) settle(1'b0);
    end
  endtask

  task automatic directed_case(input int rows, input int cols, input int win,
                               input int count, input fill_t fill);
    settle(1'b1);
    set_geometry(rows, cols, win);
    send_matrices(count, fill, 1'b0);
  endtask

  initial begin
    int gsel;
    int rows;
    int cols;
    int win;
    int count;
    board = new();
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample_value = '0;
    result_bus.ready = 1'b0;
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
    stall_left = 0;
    random_sent = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Row count and window size keep their reset values here: 128 rows, k = 3,
    // so a single column fits no window.
    write_reg(REG_MATRIX_COLS, 8'd1);
    send_matrices(1, FILL_RANDOM, 1'b0);
    settle(1'b1);
    write_reg(REG_SPARE, 8'hFF);

    directed_case(16, 16, 16, 1, FILL_MIN);
    directed_case(0, 0, 1, 4, FILL_EXTREME);
    directed_case(1, 200, 1, 1, FILL_RANDOM);
    directed_case(2, 2, 0, 1, FILL_RANDOM);
    directed_case(2, 3, 17, 1, FILL_RANDOM);
    directed_case(2, 2, 31, 1, FILL_RANDOM);
    directed_case(3, 5, 4, 1, FILL_RANDOM);
    directed_case(5, 3, 4, 1, FILL_RANDOM);
    directed_case(4, 4, 2, 1, FILL_FLAT);
    directed_case(3, 3, 3, 1, FILL_NEGATIVE);
    directed_case(5, 6, 2, 1, FILL_NARROW);

    while (random_sent < RANDOM_ITEMS) begin
      gsel = $urandom_range(0, 19);
      count = 1;
      case (gsel)
        0: begin
          rows = $urandom_range(64, 255);
          cols = $urandom_range(0, 1);
          win = $urandom_range(1, 3);
        end
        1: begin
          rows = $urandom_range(0, 1);
          cols = $urandom_range(64, 255);
          win = $urandom_range(1, 3);
        end
        2: begin
          rows = $urandom_range(12, 17);
          cols = $urandom_range(12, 17);
          win = $urandom_range(10, 16);
        end
        default: begin
          rows = $urandom_range(0, 8);
          cols = $urandom_range(0, 8);
          count = $urandom_range(1, 4);
          case ($urandom_range(0, 19))
            0: win = 0;
            1: win = $urandom_range(17, 31);
            2: win = $urandom_range(5, 16);
            default: win = $urandom_range(1, 4);
          endcase
        end
      endcase
      settle(1'b1);
      set_geometry(rows, cols, win);
      send_matrices(count, fill_t'($urandom_range(0, 6)), 1'b1);
    end

    settle(1'b1);
    if (board.outstanding() != 0)
      $error("%0d expected results never arrived", board.outstanding());
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/mswin_pkg.sv
hdl/mswin_sample_if.sv
hdl/mswin_result_if.sv
hdl/mswin_front.sv
hdl/mswin_window.sv
hdl/mswin_outq.sv
hdl/max_sum_window_search_core.sv
tb/tb_max_sum_window_search_core.sv
